// File: rtl/core/bsa_pkg.sv
`timescale 1ns / 1ps
package bsa_pkg;

    typedef enum logic [1:0] {
        OP_SET_FREE = 2'd0,
        OP_LOAD     = 2'd1,
        OP_REQUEST  = 2'd2,
        OP_QUERY    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_GRANTED  = 2'd0,
        KIND_UNSAFE   = 2'd1,
        KIND_EXCEEDS  = 2'd2,
        KIND_SEQUENCE = 2'd3
    } kind_t;

    localparam logic [0:0] CFG_PROCS = 1'b0;
    localparam logic [0:0] CFG_RES   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_APPLY,
        ST_ZCHK,
        ST_RELEASE,
        ST_S_INIT,
        ST_S_SCAN,
        ST_S_ADD,
        ST_S_NEXT,
        ST_COMMIT,
        ST_EMIT,
        ST_EMIT_SEQ
    } state_t;

    // Control from the sequencer to the shared datapath.
    typedef struct packed {
        logic cmp_fit;
        logic sat_add;
        logic sub;
    } alu_ctl_t;

endpackage

// File: rtl/core/bsa_stream_if.sv
`timescale 1ns / 1ps
interface bsa_stream_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bsa_alu.sv
`timescale 1ns / 1ps
module bsa_alu #(
    parameter int COUNT_BITS = 8
) (
    input  bsa_pkg::alu_ctl_t        ctl,
    input  logic [COUNT_BITS-1:0]    a,
    input  logic [COUNT_BITS-1:0]    b,
    output logic [COUNT_BITS-1:0]    result,
    output logic                     a_gt_b
);
    import bsa_pkg::*;

    logic [COUNT_BITS:0] sum;

    // One shared unit serves subtraction, saturating addition and compare.
    assign sum    = {1'b0, a} + {1'b0, b};
    assign a_gt_b = a > b;

    always_comb
    begin
        if (ctl.sub || ctl.cmp_fit)
            result = a - b;
        else if (ctl.sat_add && sum[COUNT_BITS])
            result = {COUNT_BITS{1'b1}};
        else
            result = sum[COUNT_BITS-1:0];
    end
endmodule

// File: rtl/core/bankers_safety_allocator.sv
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// in_ch    | sink      | opcode, proc_index, res_index, amount, max_claim, final_part
// out_ch   | source    | kind, proc_id, end_of_run
// cfg      | write     | cfg_we, cfg_index, cfg_wdata
//
// Set free, load and a non-final request part are taken while idle and can
// follow one another back to back. A final request or a query runs the safety
// search on the one shared arithmetic unit: each pass steps resource by resource
// through every unfinished process and steps over every finished one, then adds
// the chosen process's allocation back resource by resource. A request also runs
// its check and apply steps, a release when it completes, and a commit if safe.
// Reset clears all tables and counters at once; no clearing pass is needed.
// A stalled result holds the sequencer; no further input is taken until done.
module bankers_safety_allocator #(
    parameter int MAX_PROCS  = 8,
    parameter int MAX_RES    = 4,
    parameter int COUNT_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    bsa_stream_if.sink   in_ch,
    bsa_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import bsa_pkg::*;

    localparam int PB = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RB = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int PC = $clog2(MAX_PROCS + 1);
    localparam int RC = $clog2(MAX_RES + 1);

    // Input payload layout: opcode, proc_index, res_index, amount, max_claim, final_part.
    logic [1:0]            in_op;
    logic [2:0]            in_p;
    logic [1:0]            in_r;
    logic [7:0]            in_amt;
    logic [7:0]            in_mc;
    logic                  in_fin;
    assign {in_op, in_p, in_r, in_amt, in_mc, in_fin} = in_ch.data;

    // Tables, held in flip-flops: each is small and reset clears it at once.
    logic [COUNT_BITS-1:0] alloc_reg  [MAX_PROCS][MAX_RES];
    logic [COUNT_BITS-1:0] need_reg   [MAX_PROCS][MAX_RES];
    logic [COUNT_BITS-1:0] free_reg   [MAX_RES];
    logic [COUNT_BITS-1:0] staged_reg [MAX_RES];
    // Tentative copies for the trial grant; committed only when safe.
    logic [COUNT_BITS-1:0] talloc_reg [MAX_RES];
    logic [COUNT_BITS-1:0] tneed_reg  [MAX_RES];
    logic [COUNT_BITS-1:0] tfree_reg  [MAX_RES];
    logic [COUNT_BITS-1:0] work_reg   [MAX_RES];
    logic [MAX_PROCS-1:0]  done_reg;
    logic [PB-1:0]         order_reg  [MAX_PROCS];

    logic                  bad_reg;
    logic [3:0]            np_cfg_reg;
    logic [2:0]            nr_cfg_reg;
    state_t                state_reg, state_next;
    logic [PB-1:0]         p_reg;       // requesting process
    logic [PB-1:0]         sp_reg;      // scan process
    logic [RB-1:0]         r_reg;       // resource step
    logic [PC-1:0]         cnt_reg;     // processes placed
    logic                  fits_reg;
    logic                  zero_reg;
    logic                  trial_reg;   // search uses tentative row
    logic                  is_query_reg;
    logic [1:0]            kind_reg;
    logic [2:0]            pid_reg;
    logic                  ovalid_reg;
    logic                  eor_reg;
    logic [PC-1:0]         ecnt_reg;

    // Effective counts after clamping the registers.
    logic [PC-1:0] np;
    logic [RC-1:0] nr;
    always_comb
    begin
        if (np_cfg_reg == 4'd0)
            np = PC'(1);
        else if (32'(np_cfg_reg) > MAX_PROCS)
            np = PC'(MAX_PROCS);
        else
            np = PC'(np_cfg_reg);
        if (nr_cfg_reg == 3'd0)
            nr = RC'(1);
        else if (32'(nr_cfg_reg) > MAX_RES)
            nr = RC'(MAX_RES);
        else
            nr = RC'(nr_cfg_reg);
    end

    logic last_r, last_sp;
    assign last_r  = (RC'(r_reg) + RC'(1)) >= nr;
    assign last_sp = (PC'(sp_reg) + PC'(1)) >= np;

    // Row views used by the search: the tentative row replaces the requester's.
    logic [COUNT_BITS-1:0] s_need, s_alloc;
    always_comb
    begin
        if (trial_reg && sp_reg == p_reg)
        begin
            s_need  = tneed_reg[r_reg];
            s_alloc = talloc_reg[r_reg];
        end
        else
        begin
            s_need  = need_reg[sp_reg][r_reg];
            s_alloc = alloc_reg[sp_reg][r_reg];
        end
    end

    // Shared arithmetic unit and its operand selection.
    alu_ctl_t              actl;
    logic [COUNT_BITS-1:0] aa, ab, ares;
    logic                  agt;

    always_comb
    begin
        actl = '0;
        aa   = '0;
        ab   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                actl.sub = 1'b1;
                aa       = free_reg[in_r[RB-1:0]];
                ab       = COUNT_BITS'(in_amt);
            end
            ST_CHECK:
            begin
                actl.cmp_fit = 1'b1;
                aa           = staged_reg[r_reg];
                ab           = (need_reg[p_reg][r_reg] < free_reg[r_reg]) ?
                               need_reg[p_reg][r_reg] : free_reg[r_reg];
            end
            ST_APPLY:
            begin
                actl.sat_add = 1'b1;
                aa           = alloc_reg[p_reg][r_reg];
                ab           = staged_reg[r_reg];
            end
            ST_RELEASE:
            begin
                actl.sat_add = 1'b1;
                aa           = tfree_reg[r_reg];
                ab           = talloc_reg[r_reg];
            end
            ST_S_SCAN:
            begin
                actl.cmp_fit = 1'b1;
                aa           = s_need;
                ab           = work_reg[r_reg];
            end
            ST_S_ADD:
            begin
                actl.sat_add = 1'b1;
                aa           = work_reg[r_reg];
                ab           = s_alloc;
            end
            default:
            begin
                actl = '0;
            end
        endcase
    end

    bsa_alu #(.COUNT_BITS(COUNT_BITS)) u_alu (
        .ctl    (actl),
        .a      (aa),
        .b      (ab),
        .result (ares),
        .a_gt_b (agt)
    );

    logic in_fire, out_fire;
    assign in_ch.ready   = (state_reg == ST_IDLE) && !ovalid_reg;
    assign in_fire       = in_ch.valid && in_ch.ready;
    assign out_fire      = out_ch.valid && out_ch.ready;
    assign out_ch.valid  = ovalid_reg;
    assign out_ch.data   = {kind_reg, pid_reg, eor_reg};

    logic r_in_table, p_in_table, r_in_use;
    assign r_in_table = 32'(in_r) < MAX_RES;
    assign p_in_table = 32'(in_p) < MAX_PROCS;
    assign r_in_use   = RC'(in_r) < nr;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_op == OP_QUERY)
                    state_next = ST_S_INIT;
                else if (in_fire && in_op == OP_REQUEST && in_fin)
                begin
                    if (bad_reg || !r_in_use || PC'(in_p) >= np)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (agt)
                    state_next = ST_EMIT;
                else if (last_r)
                    state_next = ST_APPLY;
            end
            ST_APPLY:    if (last_r) state_next = ST_ZCHK;
            ST_ZCHK:     state_next = zero_reg ? ST_RELEASE : ST_S_INIT;
            ST_RELEASE:  if (last_r) state_next = ST_S_INIT;
            ST_S_INIT:   state_next = ST_S_SCAN;
            ST_S_SCAN:
            begin
                if (done_reg[sp_reg])
                    state_next = last_sp ? (trial_reg ? ST_EMIT : ST_EMIT) : ST_S_SCAN;
                else if (last_r && fits_reg && !agt)
                    state_next = ST_S_ADD;
                else if (last_r && last_sp)
                    state_next = ST_EMIT;
            end
            ST_S_ADD:    if (last_r) state_next = ST_S_NEXT;
            ST_S_NEXT:
            begin
                if (cnt_reg >= np)
                    state_next = is_query_reg ? ST_EMIT_SEQ : ST_COMMIT;
                else
                    state_next = ST_S_SCAN;
            end
            ST_COMMIT:   state_next = ST_EMIT;
            ST_EMIT:     if (out_fire || !ovalid_reg) state_next = ovalid_reg ? ST_IDLE : ST_EMIT;
            ST_EMIT_SEQ: if (out_fire && eor_reg) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bad_reg      <= 1'b0;
            np_cfg_reg   <= 4'd8;
            nr_cfg_reg   <= 3'd4;
            ovalid_reg   <= 1'b0;
            done_reg     <= '0;
            r_reg        <= '0;
            sp_reg       <= '0;
            cnt_reg      <= '0;
            p_reg        <= '0;
            fits_reg     <= 1'b1;
            zero_reg     <= 1'b1;
            trial_reg    <= 1'b0;
            is_query_reg <= 1'b0;
            kind_reg     <= KIND_GRANTED;
            pid_reg      <= '0;
            eor_reg      <= 1'b0;
            ecnt_reg     <= '0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                order_reg[i] <= '0;
                for (int j = 0; j < MAX_RES; j++)
                begin
                    alloc_reg[i][j] <= '0;
                    need_reg[i][j]  <= '0;
                end
            end
            for (int j = 0; j < MAX_RES; j++)
            begin
                free_reg[j]   <= '0;
                staged_reg[j] <= '0;
                talloc_reg[j] <= '0;
                tneed_reg[j]  <= '0;
                tfree_reg[j]  <= '0;
                work_reg[j]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_PROCS)
                    np_cfg_reg <= cfg_wdata;
                else
                    nr_cfg_reg <= cfg_wdata[2:0];
            end
            // A sequence entry taken mid-run is replaced by the next one below.
            if (out_fire && !(state_reg == ST_EMIT_SEQ && !eor_reg))
                ovalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in_op)
                            OP_SET_FREE:
                                if (r_in_table)
                                    free_reg[in_r[RB-1:0]] <= COUNT_BITS'(in_amt);
                            OP_LOAD:
                                if (r_in_table && p_in_table)
                                begin
                                    alloc_reg[in_p[PB-1:0]][in_r[RB-1:0]] <=
                                        COUNT_BITS'(in_amt);
                                    need_reg[in_p[PB-1:0]][in_r[RB-1:0]] <=
                                        (in_mc > in_amt) ? COUNT_BITS'(in_mc - in_amt) : '0;
                                    free_reg[in_r[RB-1:0]] <= agt ? ares : '0;
                                end
                            OP_REQUEST:
                            begin
                                if (r_in_use && !in_fin)
                                    staged_reg[in_r[RB-1:0]] <= COUNT_BITS'(in_amt);
                                else if (r_in_use)
                                    staged_reg[in_r[RB-1:0]] <= COUNT_BITS'(in_amt);
                                if (!r_in_use && !in_fin)
                                    bad_reg <= 1'b1;
                                p_reg        <= in_p[PB-1:0];
                                pid_reg      <= in_p;
                                r_reg        <= '0;
                                is_query_reg <= 1'b0;
                                trial_reg    <= 1'b1;
                                zero_reg     <= 1'b1;
                                kind_reg     <= KIND_EXCEEDS;
                            end
                            OP_QUERY:
                            begin
                                is_query_reg <= 1'b1;
                                trial_reg    <= 1'b0;
                                kind_reg     <= KIND_UNSAFE;
                                pid_reg      <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CHECK:
                begin
                    if (agt)
                        kind_reg <= KIND_EXCEEDS;
                    r_reg <= last_r ? '0 : r_reg + RB'(1);
                end
                ST_APPLY:
                begin
                    tfree_reg[r_reg]  <= free_reg[r_reg] - staged_reg[r_reg];
                    tneed_reg[r_reg]  <= need_reg[p_reg][r_reg] - staged_reg[r_reg];
                    talloc_reg[r_reg] <= ares;
                    if (need_reg[p_reg][r_reg] != staged_reg[r_reg])
                        zero_reg <= 1'b0;
                    r_reg <= last_r ? '0 : r_reg + RB'(1);
                end
                ST_RELEASE:
                begin
                    tfree_reg[r_reg]  <= ares;
                    talloc_reg[r_reg] <= '0;
                    r_reg <= last_r ? '0 : r_reg + RB'(1);
                end
                ST_S_INIT:
                begin
                    kind_reg <= KIND_UNSAFE;
                    for (int j = 0; j < MAX_RES; j++)
                        work_reg[j] <= trial_reg ? tfree_reg[j] : free_reg[j];
                    done_reg <= '0;
                    cnt_reg  <= '0;
                    sp_reg   <= '0;
                    r_reg    <= '0;
                    fits_reg <= 1'b1;
                end
                ST_S_SCAN:
                begin
                    if (done_reg[sp_reg])
                    begin
                        sp_reg <= last_sp ? '0 : sp_reg + PB'(1);
                        r_reg  <= '0;
                    end
                    else if (last_r)
                    begin
                        r_reg    <= '0;
                        fits_reg <= 1'b1;
                        if (!(fits_reg && !agt))
                            sp_reg <= last_sp ? '0 : sp_reg + PB'(1);
                    end
                    else
                    begin
                        r_reg <= r_reg + RB'(1);
                        if (agt)
                            fits_reg <= 1'b0;
                    end
                end
                ST_S_ADD:
                begin
                    work_reg[r_reg] <= ares;
                    r_reg <= last_r ? '0 : r_reg + RB'(1);
                    if (last_r)
                    begin
                        done_reg[sp_reg]       <= 1'b1;
                        order_reg[cnt_reg[PB-1:0]] <= sp_reg;
                        cnt_reg                <= cnt_reg + PC'(1);
                    end
                end
                ST_S_NEXT:
                begin
                    sp_reg   <= '0;
                    r_reg    <= '0;
                    fits_reg <= 1'b1;
                    ecnt_reg <= '0;
                end
                ST_COMMIT:
                begin
                    kind_reg <= KIND_GRANTED;
                    for (int j = 0; j < MAX_RES; j++)
                    begin
                        if (RC'(j) < nr)
                        begin
                            free_reg[j]         <= tfree_reg[j];
                            alloc_reg[p_reg][j] <= talloc_reg[j];
                            need_reg[p_reg][j]  <= tneed_reg[j];
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!ovalid_reg && state_next == ST_EMIT)
                    begin
                        ovalid_reg <= 1'b1;
                        eor_reg    <= 1'b1;
                        // Only a finished request drops its staged amounts; a
                        // query leaves a request being staged untouched.
                        if (!is_query_reg)
                        begin
                            bad_reg <= 1'b0;
                            for (int j = 0; j < MAX_RES; j++)
                                staged_reg[j] <= '0;
                        end
                    end
                end
                ST_EMIT_SEQ:
                begin
                    if (!ovalid_reg || out_fire)
                    begin
                        if (!(ovalid_reg && eor_reg))
                        begin
                            ovalid_reg <= 1'b1;
                            kind_reg   <= KIND_SEQUENCE;
                            pid_reg    <= 3'(order_reg[ecnt_reg[PB-1:0]]);
                            eor_reg    <= (ecnt_reg + PC'(1)) == np;
                            ecnt_reg   <= ecnt_reg + PC'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // A result is never offered while input is being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input ready while a result is pending");

    // A sequence entry only appears after a query.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && kind_reg == KIND_SEQUENCE) |-> is_query_reg)
        else $error("sequence entry outside a query");

    // A grant is committed only from a trial search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> trial_reg)
        else $error("commit without a trial search");
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
    import bsa_pkg::*;

    // One input transfer, unpacked into its fields. The payload is packed with
    // opcode in the most significant bits and final_part in bit 0.
    typedef struct {
        opcode_t    op;
        logic [2:0] proc_idx;
        logic [1:0] res_idx;
        logic [7:0] amount;
        logic [7:0] max_claim;
        logic       fin;
    } bank_item_t;

    // One result transfer as the predictor expects to see it.
    typedef struct {
        kind_t      kind;
        logic [2:0] pid;
        logic       last;
    } verdict_t;

    localparam int NPROC = 8;
    localparam int NRES = 4;
    localparam int CNT_MAX = 255;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 600;
    localparam int DRAIN_CYCLES = 300;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_wdata;

    bsa_stream_if #(.WIDTH(24)) in_ch ();
    bsa_stream_if #(.WIDTH(6))  out_ch ();

    bankers_safety_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // The clock runs at 100 MHz.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copy of the allocator: allocation, remaining need, free counts,
    // the request being staged, and the two configuration registers.
    int         alloc_tbl [NPROC][NRES];
    int         need_tbl [NPROC][NRES];
    int         free_cnt [NRES];
    int         staged_amt [NRES];
    bit         staged_bad;
    int         procs_reg;
    int         res_reg;

    // Scratch state for a tentative or queried safety search.
    int         try_free [NRES];
    int         try_alloc [NPROC][NRES];
    int         try_need [NPROC][NRES];
    int         safe_order [NPROC];

    bank_item_t pending_items [$];
    verdict_t   expected_verdicts [$];
    int         error_count;
    int         items_accepted;
    bit         hold_off;
    int         send_gap;
    int         recv_gap;
    int         idle_cycles;

    function automatic int active_procs();
        if (procs_reg < 1)
            return 1;
        if (procs_reg > NPROC)
            return NPROC;
        return procs_reg;
    endfunction

    function automatic int active_res();
        if (res_reg < 1)
            return 1;
        return (res_reg > NRES) ? NRES : res_reg;
    endfunction

    function automatic int add_sat(input int a, input int b);
        return (a + b > CNT_MAX) ? CNT_MAX : a + b;
    endfunction

    // Greedy search over the scratch state: the lowest-numbered unfinished
    // process whose need fits the working free vector finishes next and hands
    // back its allocation. Returns 1 when every active process finishes.
    function automatic bit find_safe_order();
        int  work [NRES];
        bit  done [NPROC];
        int  np;
        int  nr;
        int  count;
        bit  found;
        bit  fits;
        np = active_procs();
        nr = active_res();
        count = 0;
        for (int r = 0; r < NRES; r++)
            work[r] = try_free[r];
        for (int p = 0; p < NPROC; p++)
            done[p] = 1'b0;
        while (count < np)
        begin
            found = 1'b0;
            for (int p = 0; p < np && !found; p++)
            begin
                if (!done[p])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < nr; r++)
                        if (try_need[p][r] > work[r])
                            fits = 1'b0;
                    if (fits)
                    begin
                        for (int r = 0; r < nr; r++)
                            work[r] = add_sat(work[r], try_alloc[p][r]);
                        done[p] = 1'b1;
                        safe_order[count] = p;
                        count++;
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_verdict(input kind_t kind, input int pid, input bit last);
        verdict_t v;
        v.kind = kind;
        v.pid = pid[2:0];
        v.last = last;
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    // Applies one accepted item to the shadow state and queues its results.
    task automatic apply_item(input bank_item_t it);
        int    p;
        int    r;
        int    np;
        int    nr;
        kind_t kind;
        bit    all_zero;
        p = it.proc_idx;
        r = it.res_idx;
        np = active_procs();
        nr = active_res();
        case (it.op)
            OP_SET_FREE:
            begin
                free_cnt[r] = it.amount;
            end
            OP_LOAD:
            begin
                alloc_tbl[p][r] = it.amount;
                need_tbl[p][r] = (it.max_claim > it.amount) ? it.max_claim - it.amount : 0;
                free_cnt[r] = (free_cnt[r] > it.amount) ? free_cnt[r] - it.amount : 0;
            end
            OP_REQUEST:
            begin
                if (r < nr)
                    staged_amt[r] = it.amount;
                else
                    staged_bad = 1'b1;
                if (it.fin)
                begin
                    kind = KIND_GRANTED;
                    if (staged_bad || p >= np)
                        kind = KIND_EXCEEDS;
                    else
                        for (int i = 0; i < nr; i++)
                            if (staged_amt[i] > need_tbl[p][i] || staged_amt[i] > free_cnt[i])
                                kind = KIND_EXCEEDS;
                    if (kind == KIND_GRANTED)
                    begin
                        try_free = free_cnt;
                        try_alloc = alloc_tbl;
                        try_need = need_tbl;
                        all_zero = 1'b1;
                        for (int i = 0; i < nr; i++)
                        begin
                            try_free[i] -= staged_amt[i];
                            try_need[p][i] -= staged_amt[i];
                            try_alloc[p][i] = add_sat(try_alloc[p][i], staged_amt[i]);
                            if (try_need[p][i] != 0)
                                all_zero = 1'b0;
                        end
                        // A process that now needs nothing more finishes at once
                        // and returns everything it holds.
                        if (all_zero)
                            for (int i = 0; i < nr; i++)
                            begin
                                try_free[i] = add_sat(try_free[i], try_alloc[p][i]);
                                try_alloc[p][i] = 0;
                            end
                        if (find_safe_order())
                        begin
                            free_cnt = try_free;
                            alloc_tbl = try_alloc;
                            need_tbl = try_need;
                        end
                        else
                            kind = KIND_UNSAFE;
                    end
                    for (int i = 0; i < NRES; i++)
                        staged_amt[i] = 0;
                    staged_bad = 1'b0;
                    push_verdict(kind, p, 1'b1);
                end
            end
            default:
            begin
                try_free = free_cnt;
                try_alloc = alloc_tbl;
                try_need = need_tbl;
                if (!find_safe_order())
                    push_verdict(KIND_UNSAFE, 0, 1'b1);
                else
                    for (int k = 0; k < np; k++)
                        push_verdict(KIND_SEQUENCE, safe_order[k], k + 1 == np);
            end
        endcase
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: the valid/payload pair stays put while the block stalls; after a
    // transfer the next item follows after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            send_gap = 0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                apply_item(pending_items.pop_front());
                items_accepted++;
                send_gap = pick_gap();
            end
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= {pending_items[0].op, pending_items[0].proc_idx,
                               pending_items[0].res_idx, pending_items[0].amount,
                               pending_items[0].max_claim, pending_items[0].fin};
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input int seen, input int wanted);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, seen, wanted, $time);
        error_count++;
    endtask

    // Monitor: every result transfer is checked against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("unexpected result", out_ch.data, 0);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (out_ch.data[5:4] != want.kind)
                        report_mismatch("kind", out_ch.data[5:4], want.kind);
                    if (out_ch.data[3:1] != want.pid)
                        report_mismatch("proc_id", out_ch.data[3:1], want.pid);
                    if (out_ch.data[0] != want.last)
                        report_mismatch("end_of_run", out_ch.data[0], want.last);
                end
                recv_gap = pick_gap();
            end
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without a transfer on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Once the random part is under way the receiver refuses results for a
    // long stretch, so the block fills and stalls its input.
    initial
    begin
        hold_off = 1'b0;
        wait (items_accepted > 60);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
    end

    task automatic queue_item(input opcode_t op, input int p, input int r, input int amt,
                              input int mc, input bit fin);
        bank_item_t it;
        it.op = op;
        it.proc_idx = p[2:0];
        it.res_idx = r[1:0];
        it.amount = amt[7:0];
        it.max_claim = mc[7:0];
        it.fin = fin;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Waits until every item has been taken and every result checked, then
    // gives the block time to finish any set or load that causes no result.
    task automatic wait_quiet();
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (in_ch.valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[3:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PROCS)
            procs_reg = value & 15;
        else
            res_reg = value & 7;
    endtask

    // A well-formed setup: generous free counts and modest rows, so that the
    // safety search usually succeeds and requests reach the commit stage.
    task automatic queue_setup();
        for (int r = 0; r < NRES; r++)
            queue_item(OP_SET_FREE, 0, r, $urandom_range(120, 255), $urandom, 0);
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++)
            begin
                int a;
                a = $urandom_range(0, 20);
                queue_item(OP_LOAD, p, r, a, a + $urandom_range(0, 40), 0);
            end
    endtask

    // A multi-part request; occasionally with a broken part or a stray process.
    task automatic queue_request(input int max_amt);
        int nparts;
        int p;
        nparts = $urandom_range(1, NRES);
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                          : $urandom_range(0, active_procs() - 1);
        for (int k = 0; k < nparts; k++)
            queue_item(OP_REQUEST, p, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : k,
                       $urandom_range(0, max_amt), $urandom, k == nparts - 1);
    endtask

    int settings [6][2] = '{'{8, 4}, '{1, 1}, '{3, 2}, '{0, 7}, '{15, 0}, '{5, 3}};

    initial
    begin
        int roll;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PROCS;
        cfg_wdata = '0;
        error_count = 0;
        items_accepted = 0;
        idle_cycles = 0;
        procs_reg = 8;
        res_reg = 4;
        staged_bad = 1'b0;
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++)
            begin
                alloc_tbl[p][r] = 0;
                need_tbl[p][r] = 0;
            end
        for (int r = 0; r < NRES; r++)
        begin
            free_cnt[r] = 0;
            staged_amt[r] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: the query of the empty state, the count extremes,
        // a load whose claim is below its allocation, a load that drives free
        // past zero, a refused and an unsafe request, and a completing one.
        queue_item(OP_QUERY, 0, 0, 0, 0, 0);
        queue_item(OP_SET_FREE, 0, 0, 255, 0, 0);
        queue_item(OP_SET_FREE, 0, 1, 0, 255, 1);
        queue_item(OP_SET_FREE, 0, 2, 10, 0, 0);
        queue_item(OP_SET_FREE, 0, 3, 100, 0, 0);
        queue_item(OP_LOAD, 7, 3, 255, 255, 0);
        queue_item(OP_LOAD, 6, 2, 40, 5, 1);
        queue_item(OP_LOAD, 0, 0, 0, 255, 0);
        queue_item(OP_QUERY, 5, 1, 255, 255, 1);
        queue_item(OP_REQUEST, 0, 0, 255, 0, 1);
        queue_item(OP_SET_FREE, 0, 1, 50, 0, 0);
        queue_item(OP_SET_FREE, 0, 3, 50, 0, 0);
        queue_item(OP_LOAD, 7, 3, 10, 20, 0);
        queue_item(OP_REQUEST, 0, 0, 200, 0, 1);
        queue_item(OP_REQUEST, 7, 3, 10, 0, 1);
        queue_item(OP_REQUEST, 0, 0, 55, 0, 0);
        queue_item(OP_REQUEST, 0, 1, 0, 0, 1);
        queue_item(OP_QUERY, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD, 1, 0, 0, 255, 0);
        queue_item(OP_REQUEST, 1, 0, 250, 0, 1);
        queue_item(OP_QUERY, 0, 0, 0, 0, 0);
        wait_quiet();

        // Random part: each setting of the registers gets a fresh setup and a
        // mix of requests, queries, completions and stray updates.
        foreach (settings[s])
        begin
            write_reg(CFG_PROCS, settings[s][0]);
            write_reg(CFG_RES, settings[s][1]);
            queue_setup();
            for (int n = 0; n < 6; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    queue_request(($urandom_range(0, 3) == 0) ? 255 : 15);
                else if (roll < 65)
                    queue_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
                else if (roll < 80)
                begin
                    // Load a row with a small claim, then ask for exactly the
                    // rest of it so that the process completes.
                    int p;
                    int d [NRES];
                    p = $urandom_range(0, 7);
                    for (int r = 0; r < NRES; r++)
                    begin
                        d[r] = $urandom_range(0, 6);
                        queue_item(OP_LOAD, p, r, $urandom_range(0, 8) + 0, 0, 0);
                        pending_items[$].max_claim = pending_items[$].amount + d[r];
                    end
                    for (int r = 0; r < NRES; r++)
                        queue_item(OP_REQUEST, p, r, d[r], 0, r == NRES - 1);
                end
                else if (roll < 90)
                    queue_item(OP_SET_FREE, 0, $urandom, $urandom, $urandom, $urandom);
                else
                    queue_item(OP_LOAD, $urandom, $urandom, $urandom_range(0, 30),
                               $urandom, $urandom);
            end
            wait_quiet();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
